// File: src/deq_pkg.sv
// Shared constants and types for the double-ended queue.
package deq_pkg;

	localparam int DEPTH_DEF = 16;

	localparam int CMD_W    = 3;
	localparam int WORD_W   = 64;
	localparam int STATUS_W = 2;

	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_PEEK_BACK  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// Decision made by the pointer logic for one accepted beat.
	typedef struct packed {
		logic                wr_en;   // store value at addr
		logic                rd_ok;   // successful peek/pop, data comes from addr
		logic [STATUS_W-1:0] status;
	} deq_op_t;

endpackage

// File: src/deq_if.sv
// Request and response channel interfaces of the double-ended queue.
interface deq_req_if;
	logic                         valid;
	logic                         ready;
	logic [deq_pkg::CMD_W-1:0]    cmd;
	logic signed [deq_pkg::WORD_W-1:0] value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface deq_rsp_if;
	logic                            valid;
	logic                            ready;
	logic signed [deq_pkg::WORD_W-1:0] data;
	logic [deq_pkg::STATUS_W-1:0]    status;

	modport source (output valid, output data, output status, input ready);
	modport sink   (input valid, input data, input status, output ready);
endinterface

// File: src/deq_ctrl.sv
// Head and fill pointers of the ring; picks the entry address for each beat.
module deq_ctrl #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [deq_pkg::CMD_W-1:0]   cmd,
	output logic [$clog2(DEPTH)-1:0]    addr,
	output deq_pkg::deq_op_t            op
);
	import deq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = AW + 1;

	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;

	logic          empty, full;
	logic [AW-1:0] head_inc, head_dec, tail_pos, last_pos;
	logic [SW-1:0] sum_tail, sum_last;
	logic [AW-1:0] head_d;
	logic [CW-1:0] count_d;

	assign empty = (count_q == '0);
	assign full  = (count_q == CW'(DEPTH));

	assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;

	// head + count and head + count - 1 stay below twice DEPTH
	assign sum_tail = SW'(head_q) + SW'(count_q);
	assign sum_last = sum_tail - 1'b1;
	assign tail_pos = (sum_tail >= SW'(DEPTH)) ? AW'(sum_tail - SW'(DEPTH)) : AW'(sum_tail);
	assign last_pos = (sum_last >= SW'(DEPTH)) ? AW'(sum_last - SW'(DEPTH)) : AW'(sum_last);

	always_comb begin
		op      = '{wr_en: 1'b0, rd_ok: 1'b0, status: ST_OK};
		addr    = head_q;
		head_d  = head_q;
		count_d = count_q;
		case (cmd)
			CMD_PUSH_FRONT: begin
				if (full) begin
					op.status = ST_FULL;
				end else begin
					op.wr_en = 1'b1;
					addr     = head_dec;
					head_d   = head_dec;
					count_d  = count_q + 1'b1;
				end
			end
			CMD_PUSH_BACK: begin
				if (full) begin
					op.status = ST_FULL;
				end else begin
					op.wr_en = 1'b1;
					addr     = tail_pos;
					count_d  = count_q + 1'b1;
				end
			end
			CMD_PEEK_FRONT, CMD_POP_FRONT: begin
				if (empty) begin
					op.status = ST_EMPTY;
				end else begin
					op.rd_ok = 1'b1;
					addr     = head_q;
					if (cmd == CMD_POP_FRONT) begin
						head_d  = head_inc;
						count_d = count_q - 1'b1;
					end
				end
			end
			CMD_PEEK_BACK, CMD_POP_BACK: begin
				if (empty) begin
					op.status = ST_EMPTY;
				end else begin
					op.rd_ok = 1'b1;
					addr     = last_pos;
					if (cmd == CMD_POP_BACK) begin
						count_d = count_q - 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

endmodule

// File: src/double_ended_queue_core.sv
// Top level of the double-ended queue: entry memory, read stage and response register.
//
//  channel | dir | beat fields
//  --------+-----+------------------------------
//  req     | in  | cmd[2:0], value[63:0] signed
//  rsp     | out | data[63:0] signed, status[1:0]
//
// One command per cycle sustained while rsp is not stalled; each beat passes through the
// entry memory read (registered) then the response register.
// Pointers update at acceptance, so back-to-back commands see each other.
// Reset clears head and fill count at once; entries are not cleared.
// A stalled rsp holds the response register, then the read stage, then req.
module double_ended_queue_core #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	deq_req_if.sink    req,
	deq_rsp_if.source  rsp
);
	import deq_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic [WORD_W-1:0] mem [DEPTH];

	logic          accept;
	logic [AW-1:0] addr;
	deq_op_t       op;

	logic                v_s1;
	logic                rd_ok_s1;
	logic [STATUS_W-1:0] status_s1;
	logic [WORD_W-1:0]   rdata_s1;

	logic                v_q;
	logic [WORD_W-1:0]   data_q;
	logic [STATUS_W-1:0] status_q;

	logic adv_s1;

	assign adv_s1    = v_s1 && (!v_q || rsp.ready);
	assign req.ready = !v_s1 || adv_s1;
	assign accept    = req.valid && req.ready;

	deq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.cmd    (req.cmd),
		.addr   (addr),
		.op     (op)
	);

	// one access per beat, so a read never meets a write to the same entry
	always_ff @(posedge clk) begin
		if (accept && op.wr_en) begin
			mem[addr] <= req.value;
		end
		if (accept && op.rd_ok) begin
			rdata_s1 <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.ready) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_ok_s1  <= op.rd_ok;
			status_s1 <= op.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (!v_q || rsp.ready) begin
			v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			data_q   <= rd_ok_s1 ? rdata_s1 : '0;
			status_q <= status_s1;
		end
	end

	assign rsp.valid  = v_q;
	assign rsp.data   = data_q;
	assign rsp.status = status_q;

endmodule

// File: bench/double_ended_queue_core_test.sv
// Self-checking bench for the double-ended queue core: random bursty commands, scoreboarded replies.
`timescale 1ns / 1ps

module double_ended_queue_core_test;
	import deq_pkg::*;

	localparam int DEPTH       = DEPTH_DEF;
	localparam int RANDOM_CMDS = 1650;
	localparam int CYCLE_LIMIT = 200000;

	// codes the block decodes as no-ops
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	typedef struct {
		logic [CMD_W-1:0]         cmd;
		logic signed [WORD_W-1:0] value;
	} deq_cmd_t;

	typedef struct {
		logic signed [WORD_W-1:0] data;
		logic [STATUS_W-1:0]      status;
	} deq_reply_t;

	typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PERIODIC} ready_mode_t;

	logic clk;
	logic arst_n;

	deq_req_if req_ch ();
	deq_rsp_if rsp_ch ();

	double_ended_queue_core #(.DEPTH(DEPTH)) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch.sink),
		.rsp   (rsp_ch.source)
	);

	deq_cmd_t   cmd_backlog[$];
	deq_reply_t deque_replies[$];

	// shadow copy of the ring
	logic signed [WORD_W-1:0] ring_words[DEPTH];
	int unsigned front_pos  = 0;
	int unsigned word_count = 0;

	int error_count = 0;
	int cycle_count = 0;

	// sender burst state
	int  burst_left = 0;
	int  gap_left   = 0;
	bit  send_now;

	// receiver stall state
	ready_mode_t ready_mode  = RDY_ALWAYS;
	int          mode_left   = 0;
	int          mode_phase  = 0;
	bit          take_now;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic flag_error(input string what);
		error_count++;
		if (error_count <= 40)
			$display("ERROR @%0t: %s", $time, what);
	endtask

	// Advance the shadow deque by one accepted command and queue the reply it owes.
	task automatic apply_deque_cmd(input logic [CMD_W-1:0] op, input logic signed [WORD_W-1:0] word);
		deq_reply_t  r;
		int unsigned slot;
		r.data   = '0;
		r.status = ST_OK;
		case (op)
			CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				if (word_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					if (op == CMD_PUSH_FRONT) begin
						front_pos = (front_pos + DEPTH - 1) % DEPTH;
						ring_words[front_pos] = word;
					end else begin
						ring_words[(front_pos + word_count) % DEPTH] = word;
					end
					word_count++;
				end
			end
			CMD_PEEK_FRONT, CMD_PEEK_BACK, CMD_POP_FRONT, CMD_POP_BACK: begin
				if (word_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					if (op == CMD_PEEK_FRONT || op == CMD_POP_FRONT)
						slot = front_pos;
					else
						slot = (front_pos + word_count - 1) % DEPTH;
					r.data = ring_words[slot];
					if (op == CMD_POP_FRONT) begin
						front_pos = (front_pos + 1) % DEPTH;
						word_count--;
					end else if (op == CMD_POP_BACK) begin
						word_count--;
					end
				end
			end
			default: ;
		endcase
		deque_replies.insert(deque_replies.size(), r);
	endtask

	task automatic check_reply(input logic signed [WORD_W-1:0] data, input logic [STATUS_W-1:0] status);
		deq_reply_t want;
		if (deque_replies.size() == 0) begin
			flag_error($sformatf("unexpected reply data=%0d status=%0d", data, status));
		end else begin
			want = deque_replies[0];
			deque_replies.delete(0);
			if (data !== want.data)
				flag_error($sformatf("data %0d, want %0d", data, want.data));
			if (status !== want.status)
				flag_error($sformatf("status %0d, want %0d", status, want.status));
		end
	endtask

	function automatic logic signed [WORD_W-1:0] rand_word();
		logic signed [WORD_W-1:0] w;
		case ($urandom_range(0, 9))
			0: w = {1'b0, {(WORD_W-1){1'b1}}};
			1: w = {1'b1, {(WORD_W-1){1'b0}}};
			2: begin
				w = $urandom_range(0, 15);
				if ($urandom_range(0, 1)) w = -w;
			end
			default: w = {$urandom, $urandom};
		endcase
		return w;
	endfunction

	// push_pct steers the fill level: high fills toward full, low drains toward empty
	function automatic logic [CMD_W-1:0] pick_cmd(input int push_pct);
		if ($urandom_range(0, 99) < 3)
			return $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
		if ($urandom_range(0, 99) < push_pct)
			return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
		case ($urandom_range(0, 5))
			0: return CMD_PEEK_FRONT;
			1: return CMD_PEEK_BACK;
			2, 3: return CMD_POP_FRONT;
			default: return CMD_POP_BACK;
		endcase
	endfunction

	task automatic queue_cmd(input logic [CMD_W-1:0] op, input logic signed [WORD_W-1:0] word);
		deq_cmd_t c;
		c.cmd   = op;
		c.value = word;
		cmd_backlog.insert(cmd_backlog.size(), c);
	endtask

	task automatic build_stimulus();
		logic signed [WORD_W-1:0] w;
		int made;
		int block_left;
		int push_pct;
		// reads and spare codes on the empty queue
		queue_cmd(CMD_PEEK_FRONT, rand_word());
		queue_cmd(CMD_PEEK_BACK, rand_word());
		queue_cmd(CMD_POP_FRONT, rand_word());
		queue_cmd(CMD_POP_BACK, rand_word());
		queue_cmd(CMD_SPARE_LO, rand_word());
		queue_cmd(CMD_SPARE_HI, rand_word());
		// fill to capacity from both ends with extreme and random words
		for (int i = 0; i < DEPTH; i++) begin
			case (i % 4)
				0: w = {1'b0, {(WORD_W-1){1'b1}}};
				1: w = {1'b1, {(WORD_W-1){1'b0}}};
				2: w = (i % 8 == 2) ? '0 : '1;
				default: w = {$urandom, $urandom};
			endcase
			queue_cmd((i % 2) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, w);
		end
		// pushes on a full queue are refused; peeks then read both ends
		queue_cmd(CMD_PUSH_FRONT, rand_word());
		queue_cmd(CMD_PUSH_BACK, rand_word());
		queue_cmd(CMD_PEEK_FRONT, rand_word());
		queue_cmd(CMD_PEEK_BACK, rand_word());

		made = 0;
		block_left = 0;
		push_pct = 50;
		while (made < RANDOM_CMDS) begin
			if (block_left == 0) begin
				block_left = $urandom_range(8, 48);
				case ($urandom_range(0, 2))
					0: push_pct = 80;
					1: push_pct = 20;
					default: push_pct = 45;
				endcase
			end
			queue_cmd(pick_cmd(push_pct), rand_word());
			block_left--;
			made++;
		end
	endtask

	// driver: bursts of beats separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.cmd   <= '0;
			req_ch.value <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				apply_deque_cmd(req_ch.cmd, req_ch.value);
				cmd_backlog.delete(0);
			end
			if (req_ch.valid && !req_ch.ready) begin
				send_now = 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
				send_now = 1'b0;
			end else if (cmd_backlog.size() == 0) begin
				send_now = 1'b0;
			end else begin
				send_now = 1'b1;
				if (burst_left == 0)
					burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
					                                         : $urandom_range(1, 30);
				burst_left--;
				if (burst_left == 0)
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			end
			req_ch.valid <= send_now;
			if (send_now) begin
				req_ch.cmd   <= cmd_backlog[0].cmd;
				req_ch.value <= cmd_backlog[0].value;
			end else begin
				req_ch.cmd   <= $urandom_range(0, 7);
				req_ch.value <= {$urandom, $urandom};
			end
		end
	end

	// monitor: checks each reply beat and drives the stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			mode_left  = 0;
			mode_phase = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready)
				check_reply(rsp_ch.data, rsp_ch.status);
			if (mode_left == 0) begin
				ready_mode = ready_mode_t'($urandom_range(0, 3));
				mode_left  = $urandom_range(16, 120);
				mode_phase = 0;
			end
			mode_left--;
			mode_phase++;
			case (ready_mode)
				RDY_ALWAYS: take_now = 1'b1;
				RDY_COIN:   take_now = $urandom_range(0, 1);
				RDY_SPARSE: take_now = ($urandom_range(0, 3) == 0);
				default:    take_now = (mode_phase % 7) >= 3;
			endcase
			rsp_ch.ready <= take_now;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		req_ch.valid  = 1'b0;
		req_ch.cmd    = '0;
		req_ch.value  = '0;
		rsp_ch.ready  = 1'b0;
		build_stimulus();
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		while (cmd_backlog.size() != 0) @(posedge clk);
		while (deque_replies.size() != 0) @(posedge clk);
		// room for any stray reply still in the two-stage pipe
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: sim.f
src/deq_pkg.sv
src/deq_if.sv
src/deq_ctrl.sv
src/double_ended_queue_core.sv
bench/double_ended_queue_core_test.sv
